// ===== sv/mas_pkg.sv =====
`timescale 1ns / 1ps
package mas_pkg;

  localparam int ELEM_W     = 16;
  localparam int VALUE_W    = 35;
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int ADDR_W     = 6;
  localparam int LOAD_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int OP_W       = 2;
  localparam int JOB_Q_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 3'd4;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  // store write from the loader
  typedef struct packed {
    logic                     we_a;
    logic                     we_b;
    logic [ADDR_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } mem_wr_t;

  // one classified run, as handed to the execution side
  typedef struct packed {
    logic             err;
    logic             mul;
    logic             sub;
    logic [IDX_W-1:0] rlim;
    logic [IDX_W-1:0] clim;
    logic [IDX_W-1:0] klim;
    logic [DIM_W-1:0] stride_a;
    logic [DIM_W-1:0] stride_b;
  } job_t;

endpackage

// ===== sv/mas_front.sv =====
`timescale 1ns / 1ps
module mas_front #(
  parameter int DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_accept,
  input  logic signed [mas_pkg::ELEM_W-1:0] in_element,
  input  logic                              cfg_we,
  input  logic [mas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mas_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mas_pkg::mem_wr_t                  mem_wr,
  output logic                              push,
  output mas_pkg::job_t                     job
);
  import mas_pkg::*;

  localparam int DEPTH = DIM * DIM;
  localparam logic [DIM_W-1:0] DIM_V = DIM_W'(DIM);
  localparam logic [LOAD_W-1:0] DEPTH_V = LOAD_W'(DEPTH);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = (v == '0) ? DIM_W'(1) : ((v > DIM_V) ? DIM_V : v);
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] to_lim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v - DIM_W'(1);
    return d[IDX_W-1:0];
  endfunction

  logic [DIM_W-1:0]  rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [OP_W-1:0]   operation_r;
  logic [LOAD_W-1:0] load_count_r, load_count_nxt;

  logic [DIM_W-1:0]  ra, ca, rb, cb;
  logic [LOAD_W-1:0] size_a, size_b, total, b_idx, lc_inc;
  logic              in_a, run_end;

  assign ra = clamp_dim(rows_a_r);
  assign ca = clamp_dim(cols_a_r);
  assign rb = clamp_dim(rows_b_r);
  assign cb = clamp_dim(cols_b_r);

  assign size_a  = {4'b0, ra} * {4'b0, ca};
  assign size_b  = {4'b0, rb} * {4'b0, cb};
  assign total   = size_a + size_b;
  assign in_a    = load_count_r < size_a;
  assign b_idx   = load_count_r - size_a;
  assign lc_inc  = load_count_r + LOAD_W'(1);
  assign run_end = lc_inc >= total;

  // elements past the end of the B store are dropped
  assign mem_wr.we_a = in_accept && in_a;
  assign mem_wr.we_b = in_accept && !in_a && (b_idx < DEPTH_V);
  assign mem_wr.addr = in_a ? load_count_r[ADDR_W-1:0] : b_idx[ADDR_W-1:0];
  assign mem_wr.data = in_element;

  assign push = in_accept && run_end;

  always_comb begin
    load_count_nxt = load_count_r;
    if (in_accept) begin
      load_count_nxt = run_end ? '0 : lc_inc;
    end
  end

  always_comb begin
    job.mul      = (operation_r == OP_MUL);
    job.sub      = (operation_r == OP_SUB);
    job.rlim     = to_lim(ra);
    job.clim     = (operation_r == OP_MUL) ? to_lim(cb) : to_lim(ca);
    job.klim     = (operation_r == OP_MUL) ? to_lim(ca) : '0;
    job.stride_a = ca;
    job.stride_b = cb;
    unique case (operation_r)
      OP_ADD, OP_SUB: begin
        job.err = (ra != rb) || (ca != cb);
      end
      OP_MUL: begin
        job.err = (ca != rb);
      end
      default: begin
        job.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= DIM_W'(1);
      cols_a_r     <= DIM_W'(1);
      rows_b_r     <= DIM_W'(1);
      cols_b_r     <= DIM_W'(1);
      operation_r  <= OP_ADD;
      load_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS_A:    rows_a_r    <= cfg_data;
          CFG_COLS_A:    cols_a_r    <= cfg_data;
          CFG_ROWS_B:    rows_b_r    <= cfg_data;
          CFG_COLS_B:    cols_b_r    <= cfg_data;
          CFG_OPERATION: operation_r <= cfg_data[OP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/mas_job_q.sv =====
`timescale 1ns / 1ps
module mas_job_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mas_pkg::job_t job_in,
  input  logic          pop,
  output mas_pkg::job_t job_out,
  output logic          q_valid
);
  import mas_pkg::*;

  localparam int PTR_W = $clog2(JOB_Q_DEPTH);

  job_t             q_mem [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign job_out = q_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < (PTR_W+1)'(JOB_Q_DEPTH))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("job queue underflow");

endmodule

// ===== sv/mas_back.sv =====
`timescale 1ns / 1ps
module mas_back #(
  parameter int DIM = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mas_pkg::mem_wr_t                   mem_wr,
  input  mas_pkg::job_t                      job_in,
  input  logic                               job_valid,
  output logic                               pop,
  output logic                               busy,
  output logic                               out_valid,
  output logic signed [mas_pkg::VALUE_W-1:0] out_value,
  output logic [mas_pkg::IDX_W-1:0]          out_row,
  output logic [mas_pkg::IDX_W-1:0]          out_column,
  output logic                               out_error,
  output logic                               out_last
);
  import mas_pkg::*;

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic             first;
    logic             lastk;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  state_t           state_r, state_nxt;
  job_t             job_r;
  logic [IDX_W-1:0] r_r, c_r, k_r, r_nxt, c_nxt, k_nxt;

  logic                      s1_v_r, s2_v_r;
  tag_t                      s1_tag_r, s2_tag_r, tag_issue;
  logic signed [ELEM_W-1:0]  rd_a_r, rd_b_r;
  logic signed [VALUE_W-1:0] prod_r, acc_r, acc_nxt, prod_nxt;
  logic signed [VALUE_W-1:0] a_x, b_x;
  logic signed [31:0]        mprod;

  logic signed [VALUE_W-1:0] out_value_r;
  logic [IDX_W-1:0]          out_row_r, out_column_r;
  logic                      out_valid_r, out_error_r, out_last_r;

  logic       issue, k_end, c_end, r_end, emit_err, emit_res;
  logic [6:0] base_a, base_b, addr_a, addr_b;

  assign issue = (state_r == ST_RUN);
  assign busy  = issue || s1_v_r || s2_v_r;
  assign pop   = (state_r == ST_IDLE) && job_valid && !s1_v_r && !s2_v_r;

  assign k_end = (k_r == job_r.klim);
  assign c_end = (c_r == job_r.clim);
  assign r_end = (r_r == job_r.rlim);

  // flat row-major addresses
  assign base_a = {4'b0, r_r} * {3'b0, job_r.stride_a};
  assign base_b = {4'b0, k_r} * {3'b0, job_r.stride_b};
  assign addr_a = job_r.mul ? base_a + {4'b0, k_r} : base_a + {4'b0, c_r};
  assign addr_b = job_r.mul ? base_b + {4'b0, c_r} : addr_a;

  assign tag_issue.first = (k_r == '0);
  assign tag_issue.lastk = k_end;
  assign tag_issue.last  = r_end && c_end;
  assign tag_issue.row   = r_r;
  assign tag_issue.col   = c_r;

  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r;
    c_nxt = c_r;
    k_nxt = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          r_nxt = '0;
          c_nxt = '0;
          k_nxt = '0;
          state_nxt = job_in.err ? ST_IDLE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_end) begin
          k_nxt = '0;
          if (c_end) begin
            c_nxt = '0;
            r_nxt = r_r + IDX_W'(1);
            if (r_end) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            c_nxt = c_r + IDX_W'(1);
          end
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // operand stage: one product, sum or difference per cycle
  assign a_x   = VALUE_W'(rd_a_r);
  assign b_x   = VALUE_W'(rd_b_r);
  assign mprod = rd_a_r * rd_b_r;

  always_comb begin
    if (job_r.mul) begin
      prod_nxt = VALUE_W'(mprod);
    end else if (job_r.sub) begin
      prod_nxt = a_x - b_x;
    end else begin
      prod_nxt = a_x + b_x;
    end
  end

  assign acc_nxt  = s2_tag_r.first ? prod_r : acc_r + prod_r;
  assign emit_err = pop && job_in.err;
  assign emit_res = s2_v_r && s2_tag_r.lastk;

  always_ff @(posedge clk) begin
    if (mem_wr.we_a) begin
      mem_a[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    end
    if (mem_wr.we_b) begin
      mem_b[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    end
    if (issue) begin
      rd_a_r <= mem_a[addr_a[AW-1:0]];
      rd_b_r <= mem_b[addr_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job_in;
    end
    if (issue) begin
      s1_tag_r <= tag_issue;
    end
    if (s1_v_r) begin
      prod_r   <= prod_nxt;
      s2_tag_r <= s1_tag_r;
    end
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    if (emit_err) begin
      out_value_r  <= '0;
      out_row_r    <= '0;
      out_column_r <= '0;
      out_error_r  <= 1'b1;
      out_last_r   <= 1'b1;
    end else if (emit_res) begin
      out_value_r  <= acc_nxt;
      out_row_r    <= s2_tag_r.row;
      out_column_r <= s2_tag_r.col;
      out_error_r  <= 1'b0;
      out_last_r   <= s2_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      out_valid_r <= emit_err || emit_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_row    = out_row_r;
  assign out_column = out_column_r;
  assign out_error  = out_error_r;
  assign out_last   = out_last_r;

  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_r |->
      out_last_r && out_value_r == '0 && out_row_r == '0 && out_column_r == '0)
    else $error("malformed error result");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r)
    else $error("result right after the last one");

  a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> !job_r.err)
    else $error("running a job flagged as error");

endmodule

// ===== sv/matrix_add_sub_multiply.sv =====
`timescale 1ns / 1ps
// integer matrix add / subtract / multiply
//
// request channel: start with in_element; a request is taken at a rising edge
// with start high and busy low. elements of A then B arrive row-major, one per
// cycle, shapes and operation as set through the cfg_ write port beforehand
// result channel: out_valid strobes for one cycle with out_value, out_row,
// out_column, out_error and out_last; the receiver cannot stall, every result
// is taken the cycle it appears
// after the last element of B a run goes through the job queue, the sequencer,
// the store read registers, the operand stage and the accumulate step into the
// output registers; an error run gives one result
// throughput: loading is one element a cycle while busy is low; the run then
// reads rows_a*cols_a element pairs (add, subtract) or rows_a*cols_b*cols_a
// (multiply) through the one multiply-accumulate unit and the single read
// port of each store.
// busy stays high from the last element until the result pipeline drains
// reset: shapes go to 1, operation to add, the load count to zero; the
// element stores are not cleared
module matrix_add_sub_multiply #(
  parameter int DIM = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic signed [mas_pkg::ELEM_W-1:0]  in_element,
  // configuration
  input  logic                               cfg_we,
  input  logic [mas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mas_pkg::CFG_DATA_W-1:0]     cfg_data,
  // results
  output logic                               out_valid,
  output logic signed [mas_pkg::VALUE_W-1:0] out_value,
  output logic [mas_pkg::IDX_W-1:0]          out_row,
  output logic [mas_pkg::IDX_W-1:0]          out_column,
  output logic                               out_error,
  output logic                               out_last
);
  import mas_pkg::*;

  mem_wr_t mem_wr;
  job_t    job_push, job_head;
  logic    in_accept, push, pop, q_valid, back_busy;

  // no new element while a run is queued or being worked off, the stores
  // are shared between loader and execution
  assign busy      = q_valid || back_busy;
  assign in_accept = start && !busy;

  // loader: config registers, store addressing, shape check at end of run
  mas_front #(
    .DIM (DIM)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_element (in_element),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mem_wr     (mem_wr),
    .push       (push),
    .job        (job_push)
  );

  // classified runs waiting for the execution side
  mas_job_q u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_push),
    .pop     (pop),
    .job_out (job_head),
    .q_valid (q_valid)
  );

  // stores plus sequencer and multiply-accumulate pipeline
  mas_back #(
    .DIM (DIM)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_wr     (mem_wr),
    .job_in     (job_head),
    .job_valid  (q_valid),
    .pop        (pop),
    .busy       (back_busy),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_row    (out_row),
    .out_column (out_column),
    .out_error  (out_error),
    .out_last   (out_last)
  );

endmodule
